// ----- src/sinusoidal_motor_commutation_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the commutation unit RTL.
// ----------------------------------------------------------------------------
`ifndef SINUSOIDAL_MOTOR_COMMUTATION_UNIT_MACROS_SVH
`define SINUSOIDAL_MOTOR_COMMUTATION_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// lbl: label, clk: clock, rstn: active-low reset, prop: property body
`define SMCU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("smcu assertion failed");
// cond must never hold outside reset
`define SMCU_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("smcu forbidden condition");
`else
`define SMCU_ASSERT(lbl, clk, rstn, prop)
`define SMCU_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- src/smcu_pkg.sv -----
// ----------------------------------------------------------------------------
// Commutation unit package
// Shared types, codes and constants of the sinusoidal commutation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smcu_pkg;

  localparam int PHASE_BITS_DEF = 12;
  localparam int DUTY_BITS_DEF  = 16;

  // encoder counts per mechanical turn are fixed at 2^ENC_BITS
  localparam int ENC_BITS   = 12;
  localparam int CFG_DATA_W = 15;

  // shared multiplier operand width, product upper part after >> 30
  localparam int MUL_W     = 31;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int PROD_HI_W = PROD_W - 30;

  localparam logic [PROD_HI_W-1:0] SIN_C1 = 32'd1686629713;
  localparam logic [PROD_HI_W-1:0] SIN_C3 = 32'd693598668;
  localparam logic [PROD_HI_W-1:0] SIN_C5 = 32'd85569306;
  localparam logic [MUL_W-1:0]     SIN_C7 = 31'd5026995;
  localparam logic [MUL_W-1:0]     ONE_Q30 = 31'h4000_0000;

  // register indexes
  localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [1:0] REG_POLE_PAIRS  = 2'd1;
  localparam logic [1:0] REG_AMPLITUDE   = 2'd2;
  localparam logic [1:0] REG_COMMAND_ID  = 2'd3;

  // item kinds
  localparam logic CMD_ANGLE = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  // direction request codes carried in the first frame byte
  localparam logic [7:0] REQ_FWD = 8'd1;
  localparam logic [7:0] REQ_REV = 8'd2;

  typedef enum logic [1:0] {
    DIR_STOP = 2'b00,
    DIR_FWD  = 2'b01,
    DIR_REV  = 2'b11
  } dir_e;

  typedef struct packed {
    logic [11:0] zero_offset;
    logic [5:0]  pole_pairs;
    logic [14:0] amplitude;
    logic [10:0] command_id;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    zero_offset: 12'd0,
    pole_pairs:  6'd14,
    amplitude:   15'd22938,
    command_id:  11'd21
  };

  typedef struct packed {
    logic start;
    logic ack;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ELEC_MUL,
    ST_ELEC_WB,
    ST_FOLD,
    ST_X2_MUL,
    ST_X2_WB,
    ST_T5_MUL,
    ST_T5_WB,
    ST_T3_MUL,
    ST_T3_WB,
    ST_T1_MUL,
    ST_T1_WB,
    ST_S_MUL,
    ST_S_WB,
    ST_A_MUL,
    ST_A_WB,
    ST_DONE
  } core_state_e;

endpackage

// ----- src/smcu_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned MUL_W x MUL_W multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smcu_mul (
  input  logic                             clk_i,
  input  logic [smcu_pkg::MUL_W-1:0]       a_i,
  input  logic [smcu_pkg::MUL_W-1:0]       b_i,
  output logic [smcu_pkg::PROD_W-1:0]      prod_o
);

  logic [smcu_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= smcu_pkg::PROD_W'(a_i) * smcu_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ----- src/smcu_core.sv -----
// ----------------------------------------------------------------------------
// Commutation core
// Sequencer that turns one angle sample into three duties on one multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sinusoidal_motor_commutation_unit_macros.svh"

module smcu_core #(
  parameter int PHASE_BITS = smcu_pkg::PHASE_BITS_DEF,
  parameter int DUTY_BITS  = smcu_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  smcu_pkg::core_ctrl_t            ctrl_i,
  input  smcu_pkg::cfg_t                  cfg_i,
  input  logic [smcu_pkg::ENC_BITS-1:0]   angle_i,
  input  smcu_pkg::dir_e                  dir_i,
  output smcu_pkg::core_stat_t            stat_o,
  output logic [DUTY_BITS-1:0]            duty_a_o,
  output logic [DUTY_BITS-1:0]            duty_b_o,
  output logic [DUTY_BITS-1:0]            duty_c_o,
  output smcu_pkg::dir_e                  dir_o
);

  localparam int MW    = smcu_pkg::MUL_W;
  localparam int PW    = smcu_pkg::PROD_W;
  localparam int EB    = smcu_pkg::ENC_BITS;
  localparam int QTR   = 1 << (PHASE_BITS - 2);
  localparam int THIRD = ((1 << PHASE_BITS) + 1) / 3;
  localparam int XSH   = 30 - (PHASE_BITS - 2);
  localparam int RSH   = 46 - DUTY_BITS;
  localparam int LIM   = (1 << (DUTY_BITS - 1)) - 1;

  smcu_pkg::core_state_e state_q, state_d;
  smcu_pkg::dir_e        dir_q, dir_d;
  logic [1:0]            ph_q, ph_d;
  logic [EB-1:0]         mech_q, mech_d;
  logic [PHASE_BITS-1:0] p_q, p_d;
  logic [MW-1:0]         x_q, x_d;
  logic [MW-1:0]         x2_q, x2_d;
  logic [MW-1:0]         t_q, t_d;
  logic [MW-1:0]         s_q, s_d;
  logic                  neg_q, neg_d;
  logic [DUTY_BITS-1:0]  duty_q [3];
  logic [DUTY_BITS-1:0]  duty_d [3];

  logic [MW-1:0]                   mul_a;
  logic [MW-1:0]                   mul_b;
  logic [PW-1:0]                   prod;
  logic [smcu_pkg::PROD_HI_W-1:0]  prod_hi;

  logic [PHASE_BITS+EB-1:0] elec_wide;
  logic [PHASE_BITS-1:0]    elec_p;
  logic [PHASE_BITS-1:0]    cur;
  logic [1:0]               quad;
  logic [PHASE_BITS-3:0]    frac;
  logic [PHASE_BITS-2:0]    u;
  logic [PW:0]              rnd;
  logic [PW:0]              mag_w;
  logic [DUTY_BITS-1:0]     mag;

  smcu_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign prod_hi = prod[PW-1:30];

  // rescale the 12-bit electrical angle to PHASE_BITS
  assign elec_wide = {prod[EB-1:0], {PHASE_BITS{1'b0}}} >> EB;
  assign elec_p    = elec_wide[PHASE_BITS-1:0];

  // fold the current phase into one quadrant
  always_comb begin
    case (ph_q)
      2'd1:    cur = p_q - PHASE_BITS'(THIRD);
      2'd2:    cur = p_q + PHASE_BITS'(THIRD);
      default: cur = p_q;
    endcase
    quad = cur[PHASE_BITS-1:PHASE_BITS-2];
    frac = cur[PHASE_BITS-3:0];
    if (quad == 2'd0 || quad == 2'd2) begin
      u = (PHASE_BITS-1)'(QTR) - {1'b0, frac};
    end else begin
      u = {1'b0, frac};
    end
  end

  // round half up and saturate the duty magnitude
  assign rnd   = {1'b0, prod} + ((PW + 1)'(1) << (RSH - 1));
  assign mag_w = rnd >> RSH;
  assign mag   = (mag_w > (PW + 1)'(LIM)) ? DUTY_BITS'(LIM) : mag_w[DUTY_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smcu_pkg::ST_IDLE;
      dir_q   <= smcu_pkg::DIR_FWD;
      ph_q    <= 2'd0;
      x_q     <= '0;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      ph_q    <= ph_d;
      x_q     <= x_d;
      s_q     <= s_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mech_q <= mech_d;
    p_q    <= p_d;
    x2_q   <= x2_d;
    t_q    <= t_d;
    neg_q  <= neg_d;
    duty_q <= duty_d;
  end

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    ph_d    = ph_q;
    mech_d  = mech_q;
    p_d     = p_q;
    x_d     = x_q;
    x2_d    = x2_q;
    t_d     = t_q;
    s_d     = s_q;
    neg_d   = neg_q;
    duty_d  = duty_q;
    mul_a   = '0;
    mul_b   = '0;

    case (state_q)
      smcu_pkg::ST_IDLE: begin
        if (ctrl_i.start) begin
          dir_d  = dir_i;
          mech_d = angle_i - cfg_i.zero_offset;
          if (dir_i == smcu_pkg::DIR_STOP) begin
            duty_d[0] = '0;
            duty_d[1] = '0;
            duty_d[2] = '0;
            state_d   = smcu_pkg::ST_DONE;
          end else begin
            state_d = smcu_pkg::ST_ELEC_MUL;
          end
        end
      end
      smcu_pkg::ST_ELEC_MUL: begin
        mul_a   = MW'(mech_q);
        mul_b   = MW'(cfg_i.pole_pairs);
        state_d = smcu_pkg::ST_ELEC_WB;
      end
      smcu_pkg::ST_ELEC_WB: begin
        // add a quarter turn with the sign of the direction
        if (dir_q == smcu_pkg::DIR_FWD) begin
          p_d = elec_p + PHASE_BITS'(QTR);
        end else begin
          p_d = elec_p - PHASE_BITS'(QTR);
        end
        ph_d    = 2'd0;
        state_d = smcu_pkg::ST_FOLD;
      end
      smcu_pkg::ST_FOLD: begin
        x_d     = MW'(u) << XSH;
        neg_d   = (quad == 2'd1) || (quad == 2'd2);
        state_d = smcu_pkg::ST_X2_MUL;
      end
      smcu_pkg::ST_X2_MUL: begin
        mul_a   = x_q;
        mul_b   = x_q;
        state_d = smcu_pkg::ST_X2_WB;
      end
      smcu_pkg::ST_X2_WB: begin
        x2_d    = prod_hi[MW-1:0];
        state_d = smcu_pkg::ST_T5_MUL;
      end
      smcu_pkg::ST_T5_MUL: begin
        mul_a   = smcu_pkg::SIN_C7;
        mul_b   = x2_q;
        state_d = smcu_pkg::ST_T5_WB;
      end
      smcu_pkg::ST_T5_WB: begin
        t_d     = MW'(smcu_pkg::SIN_C5 - prod_hi);
        state_d = smcu_pkg::ST_T3_MUL;
      end
      smcu_pkg::ST_T3_MUL: begin
        mul_a   = t_q;
        mul_b   = x2_q;
        state_d = smcu_pkg::ST_T3_WB;
      end
      smcu_pkg::ST_T3_WB: begin
        t_d     = MW'(smcu_pkg::SIN_C3 - prod_hi);
        state_d = smcu_pkg::ST_T1_MUL;
      end
      smcu_pkg::ST_T1_MUL: begin
        mul_a   = t_q;
        mul_b   = x2_q;
        state_d = smcu_pkg::ST_T1_WB;
      end
      smcu_pkg::ST_T1_WB: begin
        t_d     = MW'(smcu_pkg::SIN_C1 - prod_hi);
        state_d = smcu_pkg::ST_S_MUL;
      end
      smcu_pkg::ST_S_MUL: begin
        mul_a   = t_q;
        mul_b   = x_q;
        state_d = smcu_pkg::ST_S_WB;
      end
      smcu_pkg::ST_S_WB: begin
        // clamp the sine to 1.0
        if (prod_hi > {1'b0, smcu_pkg::ONE_Q30}) begin
          s_d = smcu_pkg::ONE_Q30;
        end else begin
          s_d = prod_hi[MW-1:0];
        end
        state_d = smcu_pkg::ST_A_MUL;
      end
      smcu_pkg::ST_A_MUL: begin
        mul_a   = MW'(cfg_i.amplitude);
        mul_b   = s_q;
        state_d = smcu_pkg::ST_A_WB;
      end
      smcu_pkg::ST_A_WB: begin
        duty_d[ph_q] = neg_q ? (DUTY_BITS'(0) - mag) : mag;
        if (ph_q == 2'd2) begin
          state_d = smcu_pkg::ST_DONE;
        end else begin
          ph_d    = ph_q + 2'd1;
          state_d = smcu_pkg::ST_FOLD;
        end
      end
      smcu_pkg::ST_DONE: begin
        // hold until the output register takes the result
        if (ctrl_i.ack) begin
          state_d = smcu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smcu_pkg::ST_IDLE;
      end
    endcase
  end

  assign stat_o.busy = (state_q != smcu_pkg::ST_IDLE);
  assign stat_o.done = (state_q == smcu_pkg::ST_DONE);
  assign duty_a_o    = duty_q[0];
  assign duty_b_o    = duty_q[1];
  assign duty_c_o    = duty_q[2];
  assign dir_o       = dir_q;

  `SMCU_NEVER(a_ph_range, clk_i, rst_ni, ph_q == 2'd3)
  `SMCU_ASSERT(a_last_done, clk_i, rst_ni, (state_q == smcu_pkg::ST_A_WB && ph_q == 2'd2) |=> (state_q == smcu_pkg::ST_DONE))
  `SMCU_NEVER(a_sine_bound, clk_i, rst_ni, s_q > smcu_pkg::ONE_Q30)

endmodule

// ----- src/sinusoidal_motor_commutation_unit.sv -----
// Angle sample: 19 products on one 31x31 multiplier, none when stopped, then the result
// goes to the output register; no new request is taken until the core is idle again.
// CAN frame request: taken when the core is idle, may set the direction, gives no result.
// Reset: direction forward, registers to defaults, no result pending.
// ----------------------------------------------------------------------------
// Sinusoidal motor commutation unit
// Three-phase sinusoidal duties from encoder angles, direction set by CAN frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sinusoidal_motor_commutation_unit_macros.svh"

module sinusoidal_motor_commutation_unit #(
  parameter int PHASE_BITS = smcu_pkg::PHASE_BITS_DEF,
  parameter int DUTY_BITS  = smcu_pkg::DUTY_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               command_i,
  input  logic [11:0]                        angle_raw_i,
  input  logic [10:0]                        frame_id_i,
  input  logic [3:0]                         frame_len_i,
  input  logic [7:0]                         frame_byte0_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [DUTY_BITS-1:0]        duty_a_o,
  output logic signed [DUTY_BITS-1:0]        duty_b_o,
  output logic signed [DUTY_BITS-1:0]        duty_c_o,
  output logic signed [1:0]                  direction_now_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         cfg_index_i,
  input  logic [smcu_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  smcu_pkg::cfg_t       cfg_q, cfg_d;
  smcu_pkg::dir_e       dir_q, dir_d;
  smcu_pkg::core_ctrl_t core_ctrl;
  smcu_pkg::core_stat_t core_stat;
  smcu_pkg::dir_e       core_dir;
  smcu_pkg::dir_e       out_dir_q;
  logic                 out_valid_q, out_valid_d;
  logic                 in_accept;
  logic                 cfg_write;
  logic [DUTY_BITS-1:0] core_duty_a, core_duty_b, core_duty_c;
  logic [DUTY_BITS-1:0] out_duty_a_q, out_duty_b_q, out_duty_c_q;

  assign in_stall_o  = core_stat.busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  assign core_ctrl.start = in_accept && (command_i == smcu_pkg::CMD_ANGLE);
  assign core_ctrl.ack   = core_stat.done && (!out_valid_q || !out_stall_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (cfg_index_i)
        smcu_pkg::REG_ZERO_OFFSET: cfg_d.zero_offset = cfg_data_i[11:0];
        smcu_pkg::REG_POLE_PAIRS:  cfg_d.pole_pairs  = cfg_data_i[5:0];
        smcu_pkg::REG_AMPLITUDE:   cfg_d.amplitude   = cfg_data_i[14:0];
        smcu_pkg::REG_COMMAND_ID:  cfg_d.command_id  = cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // a matching frame with data sets the direction; unknown codes stop
  always_comb begin
    dir_d = dir_q;
    if (in_accept && (command_i == smcu_pkg::CMD_FRAME) &&
        (frame_id_i == cfg_q.command_id) && (frame_len_i != 4'd0)) begin
      case (frame_byte0_i)
        smcu_pkg::REQ_FWD: dir_d = smcu_pkg::DIR_FWD;
        smcu_pkg::REQ_REV: dir_d = smcu_pkg::DIR_REV;
        default:           dir_d = smcu_pkg::DIR_STOP;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (core_ctrl.ack) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= smcu_pkg::CFG_RESET;
      dir_q       <= smcu_pkg::DIR_FWD;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_ctrl.ack) begin
      out_duty_a_q <= core_duty_a;
      out_duty_b_q <= core_duty_b;
      out_duty_c_q <= core_duty_c;
      out_dir_q    <= core_dir;
    end
  end

  smcu_core #(
    .PHASE_BITS (PHASE_BITS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (core_ctrl),
    .cfg_i    (cfg_q),
    .angle_i  (angle_raw_i),
    .dir_i    (dir_q),
    .stat_o   (core_stat),
    .duty_a_o (core_duty_a),
    .duty_b_o (core_duty_b),
    .duty_c_o (core_duty_c),
    .dir_o    (core_dir)
  );

  assign out_valid_o     = out_valid_q;
  assign duty_a_o        = out_duty_a_q;
  assign duty_b_o        = out_duty_b_q;
  assign duty_c_o        = out_duty_c_q;
  assign direction_now_o = out_dir_q;

  `SMCU_ASSERT(a_angle_busy, clk_i, rst_ni, core_ctrl.start |=> core_stat.busy)
  `SMCU_ASSERT(a_frame_idle, clk_i, rst_ni, (in_accept && command_i == smcu_pkg::CMD_FRAME) |=> !core_stat.busy)
  `SMCU_ASSERT(a_load_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(core_stat.done))

endmodule

// ----- sim/commutation_checker.sv -----
// ----------------------------------------------------------------------------
// Commutation checker
// Tracks the register file and the stored direction from the request and
// write channels, predicts the three duties of every accepted angle sample
// and compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module commutation_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic                                  command_i,
  input  logic [11:0]                           angle_raw_i,
  input  logic [10:0]                           frame_id_i,
  input  logic [3:0]                            frame_len_i,
  input  logic [7:0]                            frame_byte0_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [smcu_pkg::DUTY_BITS_DEF-1:0] duty_a_i,
  input  logic signed [smcu_pkg::DUTY_BITS_DEF-1:0] duty_b_i,
  input  logic signed [smcu_pkg::DUTY_BITS_DEF-1:0] duty_c_i,
  input  logic signed [1:0]                     direction_now_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [1:0]                            cfg_index_i,
  input  logic [smcu_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output int                                    error_count_o,
  output int                                    pending_o
);

  import smcu_pkg::*;

  localparam int          PB         = PHASE_BITS_DEF;
  localparam int          DB         = DUTY_BITS_DEF;
  localparam int unsigned ENC_MASK   = (1 << ENC_BITS) - 1;
  localparam int unsigned PH_MASK    = (1 << PB) - 1;
  localparam int unsigned QUARTER    = 1 << (PB - 2);
  localparam int unsigned THIRD      = ((1 << PB) + 1) / 3;
  localparam int          DUTY_SHIFT = 46 - DB;
  localparam logic [63:0] DUTY_MAX   = (64'd1 << (DB - 1)) - 64'd1;
  localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
  localparam logic [63:0] COEF_1     = 64'd1686629713;
  localparam logic [63:0] COEF_3     = 64'd693598668;
  localparam logic [63:0] COEF_5     = 64'd85569306;
  localparam logic [63:0] COEF_7     = 64'd5026995;

  typedef struct packed {
    logic [DB-1:0] duty_a;
    logic [DB-1:0] duty_b;
    logic [DB-1:0] duty_c;
    logic [1:0]    direction_now;
  } duty_set_t;

  duty_set_t expected_duties[$];
  cfg_t      regs;
  dir_e      direction;
  int        errors;

  // sine over one quadrant in Q30, u counts out of a quarter turn
  function automatic logic [63:0] quadrant_sine(int unsigned u);
    logic [63:0] x, x2, t, s;
    x = 64'(u) << (30 - (PB - 2));
    if (x > Q30_ONE) x = Q30_ONE;
    x2 = (x * x) >> 30;
    t  = COEF_5 - ((COEF_7 * x2) >> 30);
    t  = COEF_3 - ((t * x2) >> 30);
    t  = COEF_1 - ((t * x2) >> 30);
    s  = (t * x) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    return s;
  endfunction

  function automatic logic [DB-1:0] phase_duty(int unsigned ph);
    int unsigned   quad, frac;
    logic [63:0]   s, mag;
    logic          neg;
    logic [DB-1:0] duty;
    quad = (ph >> (PB - 2)) & 3;
    frac = ph & (QUARTER - 1);
    // fold into the first quadrant, keep the cosine sign apart
    case (quad)
      0: begin s = quadrant_sine(QUARTER - frac); neg = 1'b0; end
      1: begin s = quadrant_sine(frac);           neg = 1'b1; end
      2: begin s = quadrant_sine(QUARTER - frac); neg = 1'b1; end
      default: begin s = quadrant_sine(frac);     neg = 1'b0; end
    endcase
    mag = (64'(regs.amplitude) * s + (64'd1 << (DUTY_SHIFT - 1))) >> DUTY_SHIFT;
    if (mag > DUTY_MAX) mag = DUTY_MAX;
    duty = mag[DB-1:0];
    if (neg) duty = -duty;
    return duty;
  endfunction

  function automatic duty_set_t commutate(logic [11:0] angle);
    int unsigned mech, elec, ph;
    duty_set_t   d;
    d = '0;
    if (direction == DIR_STOP) return d;
    mech = (32'(angle) - 32'(regs.zero_offset)) & ENC_MASK;
    elec = (mech * 32'(regs.pole_pairs)) & ENC_MASK;
    if (PB >= ENC_BITS) ph = elec << (PB - ENC_BITS);
    else                ph = elec >> (ENC_BITS - PB);
    ph = ((direction == DIR_FWD) ? ph + QUARTER : ph - QUARTER) & PH_MASK;
    d.duty_a        = phase_duty(ph);
    d.duty_b        = phase_duty((ph - THIRD) & PH_MASK);
    d.duty_c        = phase_duty((ph + THIRD) & PH_MASK);
    d.direction_now = direction;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    duty_set_t got, want;
    if (!rst_ni) begin
      regs      = CFG_RESET;
      direction = DIR_FWD;
      errors    = 0;
      expected_duties.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ZERO_OFFSET: regs.zero_offset = cfg_data_i[11:0];
          REG_POLE_PAIRS:  regs.pole_pairs  = cfg_data_i[5:0];
          REG_AMPLITUDE:   regs.amplitude   = cfg_data_i[14:0];
          REG_COMMAND_ID:  regs.command_id  = cfg_data_i[10:0];
          default: ;
        endcase
      end

      // compare before predicting: a result never leaves in its own request cycle
      if (out_valid_i && !out_stall_i) begin
        got = '{duty_a_i, duty_b_i, duty_c_i, direction_now_i};
        if (expected_duties.size() == 0) begin
          $error("result with no request outstanding: a=%0d b=%0d c=%0d dir=%0d",
                 duty_a_i, duty_b_i, duty_c_i, direction_now_i);
          errors++;
        end else begin
          want = expected_duties.pop_front();
          if (got.duty_a !== want.duty_a) begin
            $error("duty_a expected %0d actual %0d", $signed(want.duty_a), duty_a_i);
            errors++;
          end
          if (got.duty_b !== want.duty_b) begin
            $error("duty_b expected %0d actual %0d", $signed(want.duty_b), duty_b_i);
            errors++;
          end
          if (got.duty_c !== want.duty_c) begin
            $error("duty_c expected %0d actual %0d", $signed(want.duty_c), duty_c_i);
            errors++;
          end
          if (got.direction_now !== want.direction_now) begin
            $error("direction_now expected %0d actual %0d",
                   $signed(want.direction_now), direction_now_i);
            errors++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (command_i == CMD_FRAME) begin
          if (frame_id_i == regs.command_id && frame_len_i != 4'd0) begin
            case (frame_byte0_i)
              REQ_FWD: direction = DIR_FWD;
              REQ_REV: direction = DIR_REV;
              default: direction = DIR_STOP;
            endcase
          end
        end else begin
          expected_duties.push_back(commutate(angle_raw_i));
        end
      end
    end
    error_count_o <= errors;
    pending_o     <= expected_duties.size();
  end

endmodule

// ----- sim/tb_sinusoidal_motor_commutation_unit.sv -----
// ----------------------------------------------------------------------------
// Commutation unit testbench
// Drives angle samples and CAN frames into the commutation unit under random
// stalls on both channels, later with no stalls, rewrites the registers between
// phases and lets the checker compare every duty set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sinusoidal_motor_commutation_unit;

  import smcu_pkg::*;

  localparam int DB             = DUTY_BITS_DEF;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_REQUESTS = 171;

  typedef struct packed {
    logic        cmd;
    logic [11:0] angle;
    logic [10:0] id;
    logic [3:0]  len;
    logic [7:0]  code;
  } request_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   command;
  logic [11:0]            angle_raw;
  logic [10:0]            frame_id;
  logic [3:0]             frame_len;
  logic [7:0]             frame_byte0;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [DB-1:0]   duty_a;
  logic signed [DB-1:0]   duty_b;
  logic signed [DB-1:0]   duty_c;
  logic signed [1:0]      direction_now;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          errors;
  int          pending;
  int          in_idle_pct;
  int          out_idle_pct;
  int          idle_cycles;
  int          angles_sent;
  int          frames_sent;
  logic [10:0] active_id;

  sinusoidal_motor_commutation_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .angle_raw_i     (angle_raw),
    .frame_id_i      (frame_id),
    .frame_len_i     (frame_len),
    .frame_byte0_i   (frame_byte0),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .duty_a_o        (duty_a),
    .duty_b_o        (duty_b),
    .duty_c_o        (duty_c),
    .direction_now_o (direction_now),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  commutation_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .angle_raw_i     (angle_raw),
    .frame_id_i      (frame_id),
    .frame_len_i     (frame_len),
    .frame_byte0_i   (frame_byte0),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .duty_a_i        (duty_a),
    .duty_b_i        (duty_b),
    .duty_c_i        (duty_c),
    .direction_now_i (direction_now),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .error_count_o   (errors),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("sinusoidal_motor_commutation_unit verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic request_t angle_req(logic [11:0] angle);
    request_t r;
    r       = '0;
    r.cmd   = CMD_ANGLE;
    r.angle = angle;
    return r;
  endfunction

  function automatic request_t frame_req(logic [10:0] id, logic [3:0] len, logic [7:0] code);
    request_t r;
    r      = '0;
    r.cmd  = CMD_FRAME;
    r.id   = id;
    r.len  = len;
    r.code = code;
    return r;
  endfunction

  task automatic send_request(request_t r);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    command     <= r.cmd;
    angle_raw   <= r.angle;
    frame_id    <= r.id;
    frame_len   <= r.len;
    frame_byte0 <= r.code;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (r.cmd == CMD_ANGLE) angles_sent++;
    else                    frames_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_COMMAND_ID) active_id = data[10:0];
  endtask

  // hold the input, let every result out and the core settle
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly angles and well-formed direction frames, some foreign or empty frames
  function automatic request_t random_request();
    request_t r;
    int       pick;
    logic [7:0] code;
    pick = $urandom_range(99);
    if (pick < 78) begin
      r = angle_req(12'($urandom));
      if ($urandom_range(9) == 0) r.angle = $urandom_range(1) ? 12'hFFF : 12'h000;
    end else if (pick < 92) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7: code = REQ_FWD;
        8, 9, 10, 11, 12, 13:   code = REQ_REV;
        14, 15:                 code = 8'd0;
        default:                code = 8'($urandom);
      endcase
      r = frame_req(active_id, 4'($urandom_range(1, 15)), code);
    end else if ($urandom_range(1)) begin
      r = frame_req(active_id, 4'd0, 8'($urandom));
    end else begin
      r = frame_req(11'($urandom), 4'($urandom), 8'($urandom));
    end
    return r;
  endfunction

  initial begin
    request_t r;
    int       counted;
    logic [5:0] pp;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    command      = CMD_ANGLE;
    angle_raw    = '0;
    frame_id     = '0;
    frame_len    = '0;
    frame_byte0  = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_ZERO_OFFSET;
    cfg_data     = '0;
    idle_cycles  = 0;
    angles_sent  = 0;
    frames_sent  = 0;
    in_idle_pct  = 27;
    out_idle_pct = 58;
    active_id    = CFG_RESET.command_id;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed pass on the reset register values
    send_request(angle_req(12'h000));
    send_request(angle_req(12'hFFF));
    send_request(angle_req(12'h001));
    send_request(angle_req(12'h800));
    send_request(angle_req(12'hAAA));
    send_request(angle_req(12'h555));
    send_request(frame_req(active_id, 4'd1, REQ_REV));
    send_request(angle_req(12'h000));
    send_request(angle_req(12'h400));
    send_request(frame_req(active_id, 4'd0, 8'd0));        // empty frame, ignored
    send_request(angle_req(12'd300));
    send_request(frame_req(active_id ^ 11'h7FF, 4'd1, 8'd0)); // foreign id, ignored
    send_request(angle_req(12'd300));
    send_request(frame_req(active_id, 4'd15, 8'd0));       // stop, oversized length
    send_request(angle_req(12'hFFF));
    send_request(frame_req(active_id, 4'd8, REQ_FWD));
    send_request(angle_req(12'd77));
    send_request(frame_req(active_id, 4'd1, 8'hFF));       // unknown code stops
    send_request(angle_req(12'd5));
    send_request(frame_req(active_id, 4'd2, 8'd3));
    send_request(frame_req(active_id, 4'd1, REQ_FWD));
    send_request(angle_req(12'd4000));

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      case (ph / 2)
        0: begin in_idle_pct = 27; out_idle_pct = 58; end
        1: begin in_idle_pct = 58; out_idle_pct = 27; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      case (ph)
        0: begin
          write_reg(REG_ZERO_OFFSET, 15'h0FFF);
          write_reg(REG_POLE_PAIRS,  15'd0);
          write_reg(REG_AMPLITUDE,   15'h7FFF);
          write_reg(REG_COMMAND_ID,  15'h07FF);
        end
        1: begin
          write_reg(REG_ZERO_OFFSET, 15'h7000);
          write_reg(REG_POLE_PAIRS,  15'd63);
          write_reg(REG_AMPLITUDE,   15'd0);
          write_reg(REG_COMMAND_ID,  15'h7800);
        end
        default: begin
          pp = 6'($urandom_range(1, 32));
          write_reg(REG_ZERO_OFFSET, 15'($urandom));
          write_reg(REG_POLE_PAIRS,  {9'($urandom), pp});
          write_reg(REG_AMPLITUDE,   (ph == 2) ? 15'h7FFF : 15'($urandom));
          write_reg(REG_COMMAND_ID,  15'($urandom));
        end
      endcase
      counted = 0;
      while (counted < PHASE_REQUESTS) begin
        r = random_request();
        send_request(r);
        counted++;
      end
    end

    drain();
    $display("Sent %0d angle samples and %0d CAN frames over %0d register settings,",
             angles_sent, frames_sent, PHASE_COUNT + 1);
    $display("with sender and receiver stalls swapped, then removed.");
    if (errors == 0 && pending == 0) begin
      $display("sinusoidal_motor_commutation_unit verification clean");
    end else begin
      $display("sinusoidal_motor_commutation_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/smcu_pkg.sv
src/smcu_mul.sv
src/smcu_core.sv
src/sinusoidal_motor_commutation_unit.sv
sim/commutation_checker.sv
sim/tb_sinusoidal_motor_commutation_unit.sv
